[rtl/klfl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klfl_pkg
// Shared codes and controller/datapath interface types for the keyed linked
// list with free list.
// ----------------------------------------------------------------------------
package klfl_pkg;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;
  localparam logic [1:0] CMD_COUNT  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // fixed result field widths
  localparam int SLOT_OUT_BITS  = 8;
  localparam int COUNT_OUT_BITS = 9;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic ins_read;
    logic ins_commit;
    logic walk_read;
    logic walk_advance;
    logic hit_save;
    logic rem_unlink;
    logic rem_free;
    logic load_out;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic       free_valid;
    logic       fresh_valid;
    logic       cur_valid;
    logic       key_match;
    logic       next_valid;
    logic       step_more;
    logic       out_full;
    logic [1:0] cmd;
  } sts_t;

endpackage

[rtl/keyed_linked_list_with_free_list_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_linked_list_with_free_list_core
// Keyed singly linked list in a fixed node pool with a free list.
// ----------------------------------------------------------------------------
// One transaction in gives exactly one result out. Insert pushes a node at
// the head, taking a slot from the free list first, then the next never-used
// slot, and answers pool full when neither exists. Remove and lookup walk
// from the head and act on the first node whose key matches (the most recent
// insert of that key). Count just reports the entry count. One shared read
// port on the node pool sets the walk pace of one node per cycle. The block
// handles one transaction at a time; in_stall is high while it works. The
// result sits in an output register, so a new transaction is taken while
// the previous result still waits on out_stall. No clearing pass is needed
// after reset: the pool is only read through links that were written.
// ----------------------------------------------------------------------------
module keyed_linked_list_with_free_list_core #(
  parameter int CAPACITY  = 256,
  parameter int KEY_BITS  = 32,
  parameter int DATA_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // command channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          cmd,
  input  logic [KEY_BITS-1:0]                 key,
  input  logic [DATA_BITS-1:0]                payload,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          status,
  output logic [DATA_BITS-1:0]                found_payload,
  output logic [klfl_pkg::SLOT_OUT_BITS-1:0]  slot_used,
  output logic [klfl_pkg::COUNT_OUT_BITS-1:0] entry_count
);

  // command and status between sequencer and datapath
  klfl_pkg::ctl_t ctl;
  klfl_pkg::sts_t sts;
  logic [1:0]     res_code;

  // sequencer: accepts a transaction when idle, steps the walk
  klfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl),
    .res_code  (res_code)
  );

  // datapath: node pool, heads, walk registers, result register
  klfl_dp #(
    .CAPACITY  (CAPACITY),
    .KEY_BITS  (KEY_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .cmd           (cmd),
    .key           (key),
    .payload       (payload),
    .res_code      (res_code),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .status        (status),
    .found_payload (found_payload),
    .slot_used     (slot_used),
    .entry_count   (entry_count)
  );

endmodule

[rtl/klfl_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klfl_ctrl
// Sequencer for insert, list walk, unlink and result hand-off.
// ----------------------------------------------------------------------------
module klfl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [1:0]    cmd,
  output logic          in_stall,
  input  logic          out_stall,
  input  klfl_pkg::sts_t sts,
  output klfl_pkg::ctl_t ctl,
  output logic [1:0]    res_code
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_WALK_RD,
    S_WALK_CHK,
    S_REM_UNLINK,
    S_REM_FREE,
    S_RESP
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] res_code_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    ctl           = '0;
    state_next    = state;
    res_code_next = res_code;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          case (cmd)
            klfl_pkg::CMD_INSERT: state_next = S_INS_RD;
            klfl_pkg::CMD_REMOVE: state_next = S_WALK_RD;
            klfl_pkg::CMD_LOOKUP: state_next = S_WALK_RD;
            default: begin
              res_code_next = klfl_pkg::ST_DONE;
              state_next    = S_RESP;
            end
          endcase
        end
      end
      S_INS_RD: begin
        ctl.ins_read = 1'b1;
        state_next   = S_INS_WR;
      end
      S_INS_WR: begin
        if (sts.free_valid || sts.fresh_valid) begin
          ctl.ins_commit = 1'b1;
          res_code_next  = klfl_pkg::ST_DONE;
        end else begin
          res_code_next = klfl_pkg::ST_FULL;
        end
        state_next = S_RESP;
      end
      S_WALK_RD: begin
        if (sts.cur_valid) begin
          ctl.walk_read = 1'b1;
          state_next    = S_WALK_CHK;
        end else begin
          res_code_next = klfl_pkg::ST_NOT_FOUND;
          state_next    = S_RESP;
        end
      end
      S_WALK_CHK: begin
        if (sts.key_match) begin
          ctl.hit_save = 1'b1;
          if (sts.cmd == klfl_pkg::CMD_REMOVE) begin
            state_next = S_REM_UNLINK;
          end else begin
            res_code_next = klfl_pkg::ST_DONE;
            state_next    = S_RESP;
          end
        end else if (sts.next_valid && sts.step_more) begin
          ctl.walk_advance = 1'b1;
        end else begin
          res_code_next = klfl_pkg::ST_NOT_FOUND;
          state_next    = S_RESP;
        end
      end
      S_REM_UNLINK: begin
        ctl.rem_unlink = 1'b1;
        state_next     = S_REM_FREE;
      end
      S_REM_FREE: begin
        ctl.rem_free  = 1'b1;
        res_code_next = klfl_pkg::ST_DONE;
        state_next    = S_RESP;
      end
      S_RESP: begin
        if (!sts.out_full || !out_stall) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      res_code <= klfl_pkg::ST_DONE;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
    end
  end

endmodule

[rtl/klfl_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klfl_dp
// Node pool memories, list and free list heads, walk registers and the
// result register.
// ----------------------------------------------------------------------------
module klfl_dp #(
  parameter int CAPACITY  = 256,
  parameter int KEY_BITS  = 32,
  parameter int DATA_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  klfl_pkg::ctl_t                       ctl,
  output klfl_pkg::sts_t                       sts,
  input  logic [1:0]                           cmd,
  input  logic [KEY_BITS-1:0]                  key,
  input  logic [DATA_BITS-1:0]                 payload,
  input  logic [1:0]                           res_code,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic [1:0]                           status,
  output logic [DATA_BITS-1:0]                 found_payload,
  output logic [klfl_pkg::SLOT_OUT_BITS-1:0]   slot_used,
  output logic [klfl_pkg::COUNT_OUT_BITS-1:0]  entry_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);
  localparam logic [LW:0]   CAP_EXT = (LW + 1)'(CAPACITY);

  // node pool
  logic [KEY_BITS-1:0]  mem_key     [CAPACITY];
  logic [DATA_BITS-1:0] mem_payload [CAPACITY];
  logic [LW-1:0]        mem_link    [CAPACITY];

  logic [KEY_BITS-1:0]  rd_key;
  logic [DATA_BITS-1:0] rd_payload;
  logic [LW-1:0]        rd_link;

  logic [LW-1:0] list_head;
  logic [LW-1:0] free_head;
  logic [LW-1:0] fresh_top;
  logic [LW-1:0] live_count;

  logic [LW-1:0]        cur;
  logic [LW-1:0]        prev;
  logic [LW-1:0]        nxt;
  logic [LW-1:0]        steps;
  logic [1:0]           cmd_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [DATA_BITS-1:0] payload_q;
  logic [DATA_BITS-1:0] res_found;
  logic [AW-1:0]        res_slot;

  logic          free_valid;
  logic          fresh_valid;
  logic          prev_valid;
  logic [LW-1:0] ins_slot;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          lw_en;
  logic [AW-1:0] lw_addr;
  logic [LW-1:0] lw_data;
  logic [AW+klfl_pkg::SLOT_OUT_BITS-1:0] slot_ext;
  logic [LW+klfl_pkg::COUNT_OUT_BITS-1:0] count_ext;

  assign free_valid  = (free_head < NIL);
  assign fresh_valid = (fresh_top < NIL);
  assign prev_valid  = (prev < NIL);
  assign ins_slot    = free_valid ? free_head : fresh_top;

  assign sts.free_valid  = free_valid;
  assign sts.fresh_valid = fresh_valid;
  assign sts.cur_valid   = (cur < NIL);
  assign sts.key_match   = (rd_key == key_q);
  assign sts.next_valid  = (rd_link < NIL);
  assign sts.step_more   = (({1'b0, steps} + 1'b1) < CAP_EXT);
  assign sts.out_full    = out_valid;
  assign sts.cmd         = cmd_q;

  // single read port shared by insert and walk
  always_comb begin
    if (ctl.walk_advance) begin
      rd_addr = rd_link[AW-1:0];
    end else if (ctl.walk_read) begin
      rd_addr = cur[AW-1:0];
    end else begin
      rd_addr = free_head[AW-1:0];
    end
  end

  assign rd_en = (ctl.ins_read && free_valid) || ctl.walk_read || ctl.walk_advance;

  // single link write port
  always_comb begin
    lw_en   = 1'b0;
    lw_addr = cur[AW-1:0];
    lw_data = free_head;
    if (ctl.ins_commit) begin
      lw_en   = 1'b1;
      lw_addr = ins_slot[AW-1:0];
      lw_data = list_head;
    end else if (ctl.rem_unlink) begin
      lw_en   = prev_valid;
      lw_addr = prev[AW-1:0];
      lw_data = nxt;
    end else if (ctl.rem_free) begin
      lw_en   = 1'b1;
      lw_addr = cur[AW-1:0];
      lw_data = free_head;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins_commit) begin
      mem_key[ins_slot[AW-1:0]]     <= key_q;
      mem_payload[ins_slot[AW-1:0]] <= payload_q;
    end
    if (lw_en) begin
      mem_link[lw_addr] <= lw_data;
    end
    if (rd_en) begin
      rd_key     <= mem_key[rd_addr];
      rd_payload <= mem_payload[rd_addr];
      rd_link    <= mem_link[rd_addr];
    end
  end

  // list heads and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      list_head  <= NIL;
      free_head  <= NIL;
      fresh_top  <= '0;
      live_count <= '0;
    end else begin
      if (ctl.ins_commit) begin
        list_head  <= ins_slot;
        live_count <= live_count + 1'b1;
        if (free_valid) begin
          free_head <= rd_link;
        end else begin
          fresh_top <= fresh_top + 1'b1;
        end
      end
      if (ctl.rem_unlink && !prev_valid) begin
        list_head <= nxt;
      end
      if (ctl.rem_free) begin
        free_head <= cur;
        if (live_count != '0) begin
          live_count <= live_count - 1'b1;
        end
      end
    end
  end

  // transaction and walk registers
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q     <= cmd;
      key_q     <= key;
      payload_q <= payload;
      cur       <= list_head;
      prev      <= NIL;
      steps     <= '0;
      res_found <= '0;
      res_slot  <= '0;
    end
    if (ctl.walk_advance) begin
      prev  <= cur;
      cur   <= rd_link;
      steps <= steps + 1'b1;
    end
    if (ctl.hit_save) begin
      nxt <= rd_link;
      if (cmd_q == klfl_pkg::CMD_LOOKUP) begin
        res_found <= rd_payload;
      end
    end
    if (ctl.ins_commit) begin
      res_slot <= ins_slot[AW-1:0];
    end
    if (ctl.rem_free) begin
      res_slot <= cur[AW-1:0];
    end
  end

  // result register
  assign slot_ext  = {{klfl_pkg::SLOT_OUT_BITS{1'b0}}, res_slot};
  assign count_ext = {{klfl_pkg::COUNT_OUT_BITS{1'b0}}, live_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      status        <= res_code;
      found_payload <= res_found;
      slot_used     <= slot_ext[klfl_pkg::SLOT_OUT_BITS-1:0];
      entry_count   <= count_ext[klfl_pkg::COUNT_OUT_BITS-1:0];
    end
  end

  // every live node came from a slot that was handed out once
  a_live_bounded: assert property (@(posedge clk) disable iff (rst)
    live_count <= fresh_top)
    else $error("live count exceeds slots handed out");

  a_fresh_bounded: assert property (@(posedge clk) disable iff (rst)
    fresh_top <= NIL)
    else $error("fresh slot pointer beyond pool");

  a_insert_head: assert property (@(posedge clk) disable iff (rst)
    ctl.ins_commit |=> (list_head < NIL) && (live_count != '0))
    else $error("insert left list empty");

  a_remove_free: assert property (@(posedge clk) disable iff (rst)
    ctl.rem_free |=> (free_head < NIL))
    else $error("removed slot not on free list");

endmodule

[tb/sv/keyed_linked_list_with_free_list_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_linked_list_with_free_list_core_tb
// Self-checking bench for the keyed linked list with free list. A scoreboard
// keeps its own copy of the node pool, list and free list. It predicts every
// response and compares each one, field by field, with what the core returns.
// Traffic is a short directed set, a fill past pool full, then random churn.
// The command side idles at random and the result side stalls at random.
// ----------------------------------------------------------------------------
module keyed_linked_list_with_free_list_core_tb;

  localparam int CAP    = 256;
  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int NIL    = CAP;   // end-of-chain marker, same as the core
  localparam int QUIET_LIMIT = 4000;  // cycles with no transaction on either side
  localparam int DRAIN_PAD   = 300;   // quiet tail after the last test
  localparam int PRINT_CAP   = 40;

  typedef struct packed {
    logic [1:0]                          status;
    logic [DATA_W-1:0]                   found;
    logic [klfl_pkg::SLOT_OUT_BITS-1:0]  slot;
    logic [klfl_pkg::COUNT_OUT_BITS-1:0] count;
  } response_t;

  // dut connections, the driven inputs known from time zero
  logic                                clk       = 1'b0;
  logic                                rst       = 1'b1;
  logic                                in_valid  = 1'b0;
  logic                                in_stall;
  logic [1:0]                          cmd       = klfl_pkg::CMD_COUNT;
  logic [KEY_W-1:0]                    key       = '0;
  logic [DATA_W-1:0]                   payload   = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [1:0]                          status;
  logic [DATA_W-1:0]                   found_payload;
  logic [klfl_pkg::SLOT_OUT_BITS-1:0]  slot_used;
  logic [klfl_pkg::COUNT_OUT_BITS-1:0] entry_count;

  // scoreboard copy of the pool
  logic [KEY_W-1:0]  slot_key  [CAP];
  logic [DATA_W-1:0] slot_data [CAP];
  int                slot_link [CAP];
  int                list_top;
  int                free_top;
  int                next_fresh;
  int                entries;

  response_t awaited[$];   // predicted responses, oldest first
  int        error_count = 0;
  int        burst_left  = 0;

  // receiver stall pattern state
  int pat_kind   = 0;
  int pat_left   = 0;
  int pat_period = 2;
  int pat_phase  = 0;

  keyed_linked_list_with_free_list_core #(
    .CAPACITY  (CAP),
    .KEY_BITS  (KEY_W),
    .DATA_BITS (DATA_W)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .key           (key),
    .payload       (payload),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .found_payload (found_payload),
    .slot_used     (slot_used),
    .entry_count   (entry_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // list arithmetic
  // ---------------------------------------------------------------------------

  // first node holding k, walking from the list top; prev gets its predecessor
  function automatic int find_key(input logic [KEY_W-1:0] k, output int prev);
    int cur;
    int steps;
    prev  = NIL;
    cur   = list_top;
    steps = 0;
    while (cur != NIL && steps < CAP) begin
      if (slot_key[cur] == k) return cur;
      prev = cur;
      cur  = slot_link[cur];
      steps++;
    end
    prev = NIL;
    return NIL;
  endfunction

  // apply one command to the copy of the pool and return the response it gives
  function automatic response_t compute_response(input logic [1:0] op,
                                                 input logic [KEY_W-1:0] k,
                                                 input logic [DATA_W-1:0] d);
    response_t r;
    int        slot;
    int        prev;
    r    = '0;
    slot = NIL;
    case (op)
      klfl_pkg::CMD_INSERT: begin
        // recycled slots go first, then never-used ones
        if (free_top != NIL) begin
          slot     = free_top;
          free_top = slot_link[slot];
        end else if (next_fresh < CAP) begin
          slot = next_fresh;
          next_fresh++;
        end
        if (slot != NIL) begin
          slot_key[slot]  = k;
          slot_data[slot] = d;
          slot_link[slot] = list_top;
          list_top        = slot;
          entries++;
          r.slot = klfl_pkg::SLOT_OUT_BITS'(slot);
        end else begin
          r.status = klfl_pkg::ST_FULL;
        end
      end
      klfl_pkg::CMD_REMOVE: begin
        slot = find_key(k, prev);
        if (slot != NIL) begin
          if (prev != NIL) slot_link[prev] = slot_link[slot];
          else list_top = slot_link[slot];
          slot_link[slot] = free_top;
          free_top        = slot;
          if (entries > 0) entries--;
          r.slot = klfl_pkg::SLOT_OUT_BITS'(slot);
        end else begin
          r.status = klfl_pkg::ST_NOT_FOUND;
        end
      end
      klfl_pkg::CMD_LOOKUP: begin
        slot = find_key(k, prev);
        if (slot != NIL) r.found = slot_data[slot];
        else r.status = klfl_pkg::ST_NOT_FOUND;
      end
      default: begin
        // count: nothing moves, only the count is reported
      end
    endcase
    r.count = klfl_pkg::COUNT_OUT_BITS'(entries);
    return r;
  endfunction

  // key of the node at a given depth below the list top
  function automatic logic [KEY_W-1:0] key_at_depth(input int depth);
    int cur;
    cur = list_top;
    repeat (depth) cur = slot_link[cur];
    return slot_key[cur];
  endfunction

  // half the keys hit live nodes when there are any, the rest come from a tiny
  // pool (duplicates and near misses), the all-ones key or the full 32-bit range
  function automatic logic [KEY_W-1:0] choose_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50 && entries > 0) return key_at_depth($urandom_range(0, entries - 1));
    if (roll < 75) return KEY_W'($urandom_range(0, 7));
    if (roll < 80) return '1;
    return $urandom;
  endfunction

  function automatic logic [KEY_W-1:0] absent_key();
    logic [KEY_W-1:0] k;
    int               prev;
    do k = $urandom; while (find_key(k, prev) != NIL);
    return k;
  endfunction

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------

  // present one transaction, hold it until taken, then maybe leave a gap;
  // inside a burst valid stays high and the next call swaps the fields
  task automatic push_command(input logic [1:0] op, input logic [KEY_W-1:0] k,
                              input logic [DATA_W-1:0] d);
    cmd      <= op;
    key      <= k;
    payload  <= d;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    awaited.push_back(compute_response(op, k, d));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      // mostly short gaps, now and then a long one
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 20)) @(posedge clk);
      else repeat ($urandom_range(1, 4)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  // drop valid and wait until every predicted response has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver stall: open stretches, coin flips, periodic stalls, solid blocks
  always @(posedge clk) begin
    if (pat_left == 0) begin
      pat_kind   = $urandom_range(0, 3);
      pat_left   = (pat_kind == 3) ? $urandom_range(1, 30) : $urandom_range(20, 200);
      pat_period = $urandom_range(2, 9);
      pat_phase  = 0;
    end
    pat_left--;
    pat_phase++;
    case (pat_kind)
      0:       out_stall <= 1'b0;
      1:       out_stall <= 1'($urandom_range(0, 1));
      2:       out_stall <= (pat_phase % pat_period) < (pat_period / 2);
      default: out_stall <= 1'b1;
    endcase
  end

  task automatic report_err(input string what, input logic [31:0] got,
                            input logic [31:0] want);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
  endtask

  // every accepted response is matched against the oldest prediction
  always @(posedge clk) begin : check_responses
    response_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        report_err("response with no transaction pending", 32'(status), 32'd0);
      end else begin
        want = awaited.pop_front();
        if (status !== want.status)
          report_err("status", 32'(status), 32'(want.status));
        if (found_payload !== want.found)
          report_err("found_payload", found_payload, want.found);
        if (slot_used !== want.slot)
          report_err("slot_used", 32'(slot_used), 32'(want.slot));
        if (entry_count !== want.count)
          report_err("entry_count", 32'(entry_count), 32'(want.count));
      end
    end
  end

  // watchdog: too long with no transaction on either channel ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("keyed_linked_list_with_free_list_core_tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every command, empty-list misses, extreme keys and payloads, duplicates,
  // head/middle/tail unlinks and slot reuse from the free list
  task automatic test_basic_ops();
    push_command(klfl_pkg::CMD_COUNT,  32'h0000_0000, 32'hFFFF_FFFF);  // ignored payload
    push_command(klfl_pkg::CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);  // empty list miss
    push_command(klfl_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    push_command(klfl_pkg::CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
    push_command(klfl_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_command(klfl_pkg::CMD_INSERT, 32'h0000_0000, 32'hA5A5_A5A5);  // duplicate key
    push_command(klfl_pkg::CMD_INSERT, 32'h8000_0001, 32'h5A5A_5A5A);
    push_command(klfl_pkg::CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);  // newest wins
    push_command(klfl_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    push_command(klfl_pkg::CMD_LOOKUP, 32'h7FFF_FFFE, 32'hFFFF_FFFF);  // miss over list
    push_command(klfl_pkg::CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);  // middle node
    push_command(klfl_pkg::CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);  // older duplicate
    push_command(klfl_pkg::CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);  // tail node
    push_command(klfl_pkg::CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    push_command(klfl_pkg::CMD_INSERT, 32'h1234_5678, 32'h8765_4321);  // from free list
    push_command(klfl_pkg::CMD_INSERT, 32'hEDCB_A987, 32'h0000_0001);  // from free list
    push_command(klfl_pkg::CMD_INSERT, 32'h0000_0001, 32'h8000_0000);  // fresh slot
    push_command(klfl_pkg::CMD_REMOVE, 32'h0000_0001, 32'h0000_0000);  // head node
    push_command(klfl_pkg::CMD_REMOVE, 32'h8000_0001, 32'h0000_0000);
    push_command(klfl_pkg::CMD_REMOVE, 32'h8000_0001, 32'h0000_0000);  // already gone
    push_command(klfl_pkg::CMD_COUNT,  32'hFFFF_FFFF, 32'h0000_0000);
    settle();
  endtask

  // fill every slot, insert past full, walk the full list both ways, then
  // free and refill a few slots
  task automatic test_pool_full();
    while (entries < CAP) push_command(klfl_pkg::CMD_INSERT, choose_key(), $urandom);
    push_command(klfl_pkg::CMD_INSERT, $urandom, 32'hFFFF_FFFF);
    push_command(klfl_pkg::CMD_INSERT, 32'h0000_0000, $urandom);
    push_command(klfl_pkg::CMD_COUNT, $urandom, $urandom);
    push_command(klfl_pkg::CMD_LOOKUP, key_at_depth(CAP - 1), $urandom);  // deepest node
    push_command(klfl_pkg::CMD_LOOKUP, absent_key(), $urandom);           // walk bound
    push_command(klfl_pkg::CMD_REMOVE, key_at_depth(CAP - 1), $urandom);
    push_command(klfl_pkg::CMD_REMOVE, key_at_depth(0), $urandom);
    push_command(klfl_pkg::CMD_REMOVE, absent_key(), $urandom);
    push_command(klfl_pkg::CMD_INSERT, choose_key(), $urandom);
    push_command(klfl_pkg::CMD_INSERT, choose_key(), $urandom);
    push_command(klfl_pkg::CMD_INSERT, choose_key(), $urandom);           // full again
    push_command(klfl_pkg::CMD_COUNT, $urandom, $urandom);
    settle();
  endtask

  // random mix with a chosen remove share; lookups stay at 30 percent and
  // counts at 10, inserts take what is left
  task automatic test_random_churn(input int n_items, input int remove_pct);
    int         i;
    int         roll;
    logic [1:0] op;
    for (i = 0; i < n_items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) op = klfl_pkg::CMD_COUNT;
      else if (roll < 10 + remove_pct) op = klfl_pkg::CMD_REMOVE;
      else if (roll < 40 + remove_pct) op = klfl_pkg::CMD_LOOKUP;
      else op = klfl_pkg::CMD_INSERT;
      push_command(op, choose_key(), $urandom);
    end
    settle();
  endtask

  initial begin
    list_top   = NIL;
    free_top   = NIL;
    next_fresh = 0;
    entries    = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_ops();
    test_pool_full();
    test_random_churn(130, 30);  // balanced, near full pool
    test_random_churn(130, 50);  // drains the list, grows the free list
    test_random_churn(100, 15);  // refills from recycled slots

    // quiet tail: a stray extra response would still be caught here
    repeat (DRAIN_PAD) @(posedge clk);
    if (error_count == 0) $display("keyed_linked_list_with_free_list_core_tb: clean");
    else $display("keyed_linked_list_with_free_list_core_tb: errors");
    $finish;
  end

endmodule

[filelist.f]
rtl/klfl_pkg.sv
rtl/klfl_ctrl.sv
rtl/klfl_dp.sv
rtl/keyed_linked_list_with_free_list_core.sv
tb/sv/keyed_linked_list_with_free_list_core_tb.sv
